@@ rtl/ptop_pkg.sv @@
// ----------------------------------------------------------------------------
// ptop_pkg
// shared types and constants of the periodic tick overrun policy block
// ----------------------------------------------------------------------------
package ptop_pkg;

	localparam int IDX_W     = 40;   // period index and delivery number
	localparam int TIME_W    = 64;   // elapsed time in ms
	localparam int LATE_W    = 30;
	localparam int FC_W      = 32;   // fire count / skipped ticks
	localparam int PERIOD_W  = 24;
	localparam int MODE_W    = 2;
	localparam int LIMIT_W   = 7;
	localparam int CNT_W     = 7;    // ticks per report, up to 64
	localparam int HALF_W    = IDX_W / 2;
	localparam int PP_W      = PERIOD_W + HALF_W;
	localparam int WR_IDX_W  = 2;
	localparam int WR_DATA_W = 24;

	localparam int MAX_BURST_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	// overrun modes
	localparam logic [MODE_W-1:0] MODE_COALESCE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELAY    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CATCHUP  = 2'd2;

	// register indexes
	localparam logic [WR_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [WR_IDX_W-1:0] REG_PERIOD = 2'd1;
	localparam logic [WR_IDX_W-1:0] REG_LIMIT  = 2'd2;

	localparam logic [MODE_W-1:0]   MODE_RST   = MODE_COALESCE;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 7'd1;

	localparam logic [LATE_W-1:0] LATE_MAX = {LATE_W{1'b1}};

	// one classified report, handed from front to back
	typedef struct packed {
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] started_idx;
		logic [IDX_W-1:0] base_dn;
		logic [FC_W-1:0]  skipped;
		logic [CNT_W-1:0] count;
	} entry_t;

endpackage

@@ rtl/ptop_report_if.sv @@
// ----------------------------------------------------------------------------
// ptop_report_if
// request channel carrying one timer report
// ----------------------------------------------------------------------------
interface ptop_report_if;
	logic                      valid;
	logic                      ready;
	logic [ptop_pkg::FC_W-1:0] elapsed_periods;

	modport source (output valid, output elapsed_periods, input ready);
	modport sink (input valid, input elapsed_periods, output ready);
endinterface

@@ rtl/ptop_tick_if.sv @@
// ----------------------------------------------------------------------------
// ptop_tick_if
// request channel carrying one delivered tick
// ----------------------------------------------------------------------------
interface ptop_tick_if;
	logic                        valid;
	logic                        ready;
	logic [ptop_pkg::IDX_W-1:0]  delivery_number;
	logic [ptop_pkg::IDX_W-1:0]  sched_index;
	logic [ptop_pkg::TIME_W-1:0] scheduled_elapsed;
	logic [ptop_pkg::TIME_W-1:0] start_elapsed;
	logic [ptop_pkg::LATE_W-1:0] lateness;
	logic [ptop_pkg::FC_W-1:0]   skip_count;
	logic                        last_of_burst;

	modport source (output valid, output delivery_number, output sched_index,
		output scheduled_elapsed, output start_elapsed, output lateness,
		output skip_count, output last_of_burst, input ready);
	modport sink (input valid, input delivery_number, input sched_index,
		input scheduled_elapsed, input start_elapsed, input lateness,
		input skip_count, input last_of_burst, output ready);
endinterface

@@ rtl/ptop_front.sv @@
// ----------------------------------------------------------------------------
// ptop_front
// accepts reports, applies the overrun mode and tracks index and count state
// ----------------------------------------------------------------------------
module ptop_front #(
	parameter int MAX_BURST = ptop_pkg::MAX_BURST_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ptop_report_if.sink                  report,
	input  logic [ptop_pkg::MODE_W-1:0]  mode,
	input  logic [ptop_pkg::LIMIT_W-1:0] limit,
	input  logic                         full,
	output logic                         push,
	output ptop_pkg::entry_t             entry
);

	logic [ptop_pkg::IDX_W-1:0] last_sched_q;
	logic [ptop_pkg::IDX_W-1:0] total_q;

	logic [ptop_pkg::FC_W-1:0]  fc;
	logic [ptop_pkg::CNT_W-1:0] lim;
	logic [ptop_pkg::CNT_W-1:0] cnt;
	logic [ptop_pkg::FC_W-1:0]  skip;
	logic [ptop_pkg::IDX_W-1:0] due;
	logic [ptop_pkg::IDX_W-1:0] next_last;

	localparam logic [ptop_pkg::CNT_W-1:0] BURST_MAX = ptop_pkg::CNT_W'(MAX_BURST);

	assign report.ready = !full;
	assign push         = report.valid && !full;

	always_comb begin
		fc = (report.elapsed_periods == '0) ? ptop_pkg::FC_W'(1) : report.elapsed_periods;
		// limit of zero acts as one, above the burst size acts as the burst size
		if (limit == '0) begin
			lim = ptop_pkg::CNT_W'(1);
		end else if (ptop_pkg::CNT_W'(limit) > BURST_MAX) begin
			lim = BURST_MAX;
		end else begin
			lim = ptop_pkg::CNT_W'(limit);
		end
		due = last_sched_q + ptop_pkg::IDX_W'(fc);

		case (mode)
			ptop_pkg::MODE_DELAY: begin
				cnt                = ptop_pkg::CNT_W'(1);
				skip               = '0;
				next_last          = last_sched_q + ptop_pkg::IDX_W'(1);
				entry.first_idx    = next_last;
				entry.started_idx  = total_q + ptop_pkg::IDX_W'(1);
			end
			ptop_pkg::MODE_CATCHUP: begin
				cnt = (fc < ptop_pkg::FC_W'(lim)) ? fc[ptop_pkg::CNT_W-1:0] : lim;
				skip               = fc - ptop_pkg::FC_W'(cnt);
				next_last          = due;
				entry.first_idx    = last_sched_q + ptop_pkg::IDX_W'(skip)
					+ ptop_pkg::IDX_W'(1);
				entry.started_idx  = due;
			end
			default: begin
				// coalesce, unused mode code too
				cnt                = ptop_pkg::CNT_W'(1);
				skip               = fc - ptop_pkg::FC_W'(1);
				next_last          = due;
				entry.first_idx    = due;
				entry.started_idx  = due;
			end
		endcase

		entry.base_dn = total_q;
		entry.skipped = skip;
		entry.count   = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sched_q <= '0;
			total_q      <= '0;
		end else if (push) begin
			last_sched_q <= next_last;
			total_q      <= total_q + ptop_pkg::IDX_W'(cnt);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (entry.count != '0 && entry.count <= BURST_MAX))
		else $error("burst length out of range");

	a_delay_single: assert property (@(posedge clk) disable iff (!arst_n)
		(push && mode == ptop_pkg::MODE_DELAY) |-> (entry.count == ptop_pkg::CNT_W'(1)
			&& entry.skipped == '0))
		else $error("delay mode must give one tick without skips");

endmodule

@@ rtl/ptop_queue.sv @@
// ----------------------------------------------------------------------------
// ptop_queue
// short queue of classified reports between front and back
// ----------------------------------------------------------------------------
module ptop_queue #(
	parameter int DEPTH = ptop_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ptop_pkg::entry_t push_entry,
	input  logic             pop,
	output ptop_pkg::entry_t head,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	ptop_pkg::entry_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty) && fill_q <= CNT_W'(DEPTH))
		else $error("queue overflow or underflow");

endmodule

@@ rtl/ptop_back.sv @@
// ----------------------------------------------------------------------------
// ptop_back
// expands one classified report into ticks, computes times and lateness
// ----------------------------------------------------------------------------
module ptop_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ptop_pkg::PERIOD_W-1:0] period,
	input  ptop_pkg::entry_t              head,
	input  logic                          empty,
	output logic                          pop,
	ptop_tick_if.source                   tick
);

	// burst sequencer
	logic                       active_q;
	logic [ptop_pkg::CNT_W-1:0] rem_q;
	logic [ptop_pkg::IDX_W-1:0] idx_q;
	logic [ptop_pkg::IDX_W-1:0] dn_q;
	logic [ptop_pkg::IDX_W-1:0] start_idx_q;
	logic [ptop_pkg::FC_W-1:0]  skip_q;

	// stage 1: partial products
	logic                       vld_s1;
	logic [ptop_pkg::IDX_W-1:0] idx_s1;
	logic [ptop_pkg::IDX_W-1:0] dn_s1;
	logic [ptop_pkg::FC_W-1:0]  skip_s1;
	logic                       last_s1;
	logic [ptop_pkg::PP_W-1:0]  sched_lo_s1;
	logic [ptop_pkg::PP_W-1:0]  sched_hi_s1;
	logic [ptop_pkg::PP_W-1:0]  start_lo_s1;
	logic [ptop_pkg::PP_W-1:0]  start_hi_s1;

	// stage 2: full products
	logic                        vld_s2;
	logic [ptop_pkg::IDX_W-1:0]  idx_s2;
	logic [ptop_pkg::IDX_W-1:0]  dn_s2;
	logic [ptop_pkg::FC_W-1:0]   skip_s2;
	logic                        last_s2;
	logic [ptop_pkg::TIME_W-1:0] sched_s2;
	logic [ptop_pkg::TIME_W-1:0] start_s2;

	// output register
	logic                        out_vld_q;
	logic [ptop_pkg::IDX_W-1:0]  out_dn_q;
	logic [ptop_pkg::IDX_W-1:0]  out_idx_q;
	logic [ptop_pkg::TIME_W-1:0] out_sched_q;
	logic [ptop_pkg::TIME_W-1:0] out_start_q;
	logic [ptop_pkg::LATE_W-1:0] out_late_q;
	logic [ptop_pkg::FC_W-1:0]   out_skip_q;
	logic                        out_last_q;

	logic                        adv;
	logic                        issue;
	logic [ptop_pkg::TIME_W-1:0] diff;
	logic [ptop_pkg::LATE_W-1:0] late;

	assign adv   = !out_vld_q || tick.ready;
	assign issue = active_q && adv;
	assign pop   = !active_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			rem_q    <= head.count;
		end else if (issue) begin
			active_q <= (rem_q != ptop_pkg::CNT_W'(1));
			rem_q    <= rem_q - ptop_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q       <= head.first_idx;
			dn_q        <= head.base_dn + ptop_pkg::IDX_W'(1);
			start_idx_q <= head.started_idx;
			skip_q      <= head.skipped;
		end else if (issue) begin
			idx_q  <= idx_q + ptop_pkg::IDX_W'(1);
			dn_q   <= dn_q + ptop_pkg::IDX_W'(1);
			skip_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= issue;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_comb begin
		diff = start_s2 - sched_s2;
		if (start_s2 < sched_s2) begin
			late = '0;
		end else if (diff[ptop_pkg::TIME_W-1:ptop_pkg::LATE_W] != '0) begin
			late = ptop_pkg::LATE_MAX;
		end else begin
			late = diff[ptop_pkg::LATE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1      <= idx_q;
			dn_s1       <= dn_q;
			skip_s1     <= skip_q;
			last_s1     <= (rem_q == ptop_pkg::CNT_W'(1));
			sched_lo_s1 <= ptop_pkg::PP_W'(period) * ptop_pkg::PP_W'(idx_q[ptop_pkg::HALF_W-1:0]);
			sched_hi_s1 <= ptop_pkg::PP_W'(period)
				* ptop_pkg::PP_W'(idx_q[ptop_pkg::IDX_W-1:ptop_pkg::HALF_W]);
			start_lo_s1 <= ptop_pkg::PP_W'(period)
				* ptop_pkg::PP_W'(start_idx_q[ptop_pkg::HALF_W-1:0]);
			start_hi_s1 <= ptop_pkg::PP_W'(period)
				* ptop_pkg::PP_W'(start_idx_q[ptop_pkg::IDX_W-1:ptop_pkg::HALF_W]);

			idx_s2   <= idx_s1;
			dn_s2    <= dn_s1;
			skip_s2  <= skip_s1;
			last_s2  <= last_s1;
			sched_s2 <= ptop_pkg::TIME_W'(sched_lo_s1)
				+ {sched_hi_s1, {ptop_pkg::HALF_W{1'b0}}};
			start_s2 <= ptop_pkg::TIME_W'(start_lo_s1)
				+ {start_hi_s1, {ptop_pkg::HALF_W{1'b0}}};

			out_dn_q    <= dn_s2;
			out_idx_q   <= idx_s2;
			out_sched_q <= sched_s2;
			out_start_q <= start_s2;
			out_late_q  <= late;
			out_skip_q  <= skip_s2;
			out_last_q  <= last_s2;
		end
	end

	assign tick.valid             = out_vld_q;
	assign tick.delivery_number   = out_dn_q;
	assign tick.sched_index       = out_idx_q;
	assign tick.scheduled_elapsed = out_sched_q;
	assign tick.start_elapsed     = out_start_q;
	assign tick.lateness          = out_late_q;
	assign tick.skip_count        = out_skip_q;
	assign tick.last_of_burst     = out_last_q;

	a_active_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> rem_q != '0)
		else $error("burst active with nothing left");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !issue)
		else $error("new report loaded during a burst");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !adv) |=> (vld_s2 && $stable(sched_s2) && $stable(dn_s2)))
		else $error("pipeline stage lost under stall");

endmodule

@@ rtl/periodic_tick_overrun_policy_top.sv @@
// ----------------------------------------------------------------------------
// periodic_tick_overrun_policy_top
// turns periodic timer reports into delivered ticks under an overrun mode
// ----------------------------------------------------------------------------
// first tick of a report passes queue, sequencer, stage 1, stage 2, output reg
// bursts: a report giving n ticks (1..MAX_BURST) holds the tick unit for a load
//   step then one tick per cycle while the tick side is ready; the tick unit is
//   the limit, the front keeps taking reports while the queue has room
// reset: arst_n clears index and delivery state, queue and pipeline at once,
//   registers return to coalesce mode, 1000 ms period, catch-up limit 1
module periodic_tick_overrun_policy_top #(
	parameter int MAX_BURST   = ptop_pkg::MAX_BURST_DEF,
	parameter int QUEUE_DEPTH = ptop_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ptop_report_if.sink                    report,
	ptop_tick_if.source                    tick,
	input  logic                           wr_en,
	input  logic [ptop_pkg::WR_IDX_W-1:0]  wr_index,
	input  logic [ptop_pkg::WR_DATA_W-1:0] wr_data
);

	// configuration registers, user written only while block idle, not enforced
	logic [ptop_pkg::MODE_W-1:0]   mode_q;
	logic [ptop_pkg::PERIOD_W-1:0] period_q;
	logic [ptop_pkg::LIMIT_W-1:0]  limit_q;

	// front to queue
	logic             push;
	ptop_pkg::entry_t push_entry;
	logic             full;

	// queue to back
	ptop_pkg::entry_t head;
	logic             empty;
	logic             pop;

	// register write decode; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ptop_pkg::MODE_RST;
			period_q <= ptop_pkg::PERIOD_RST;
			limit_q  <= ptop_pkg::LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				ptop_pkg::REG_MODE:   mode_q   <= wr_data[ptop_pkg::MODE_W-1:0];
				ptop_pkg::REG_PERIOD: period_q <= wr_data[ptop_pkg::PERIOD_W-1:0];
				ptop_pkg::REG_LIMIT:  limit_q  <= wr_data[ptop_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// front: takes a report, picks first index, tick count and skips,
	// and advances the scheduled index and delivery count right away
	ptop_front #(
		.MAX_BURST (MAX_BURST)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.report (report),
		.mode   (mode_q),
		.limit  (limit_q),
		.full   (full),
		.push   (push),
		.entry  (push_entry)
	);

	// short queue so front and back stall independently
	ptop_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	// back: one tick per cycle while the tick side is ready, period times index
	// split in two halves, then lateness with clamp at zero and saturation
	ptop_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.period (period_q),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.tick   (tick)
	);

endmodule

@@ test/tb_periodic_tick_overrun_policy_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_tick_overrun_policy_top
// self-checking bench: timer reports go in, the delivered ticks are checked
// field by field against a tick predictor kept in step with the register file
// ----------------------------------------------------------------------------
module tb_periodic_tick_overrun_policy_top;

	localparam int          CYCLE_LIMIT = 500000;
	localparam int          HOLD_CYCLES = 400;     // long tick stall
	localparam logic [31:0] FC_MAX      = 32'hFFFF_FFFF;
	localparam logic [23:0] PERIOD_MAX  = 24'hFF_FFFF;

	// one predicted tick
	typedef struct packed {
		logic [ptop_pkg::IDX_W-1:0]  dn;
		logic [ptop_pkg::IDX_W-1:0]  idx;
		logic [ptop_pkg::TIME_W-1:0] sched;
		logic [ptop_pkg::TIME_W-1:0] started;
		logic [ptop_pkg::LATE_W-1:0] late;
		logic [ptop_pkg::FC_W-1:0]   skipped;
		logic                        last;
	} tick_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           wr_en;
	logic [ptop_pkg::WR_IDX_W-1:0]  wr_index;
	logic [ptop_pkg::WR_DATA_W-1:0] wr_data;

	ptop_report_if report ();
	ptop_tick_if   tick ();

	periodic_tick_overrun_policy_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.report   (report),
		.tick     (tick),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// predictor copy of registers and state
	logic [ptop_pkg::MODE_W-1:0]   mode_r;
	logic [ptop_pkg::PERIOD_W-1:0] period_r;
	logic [ptop_pkg::LIMIT_W-1:0]  limit_r;
	logic [ptop_pkg::IDX_W-1:0]    last_sched_r;
	logic [ptop_pkg::IDX_W-1:0]    delivered_r;

	logic [31:0] reports_pending[$];   // reports waiting for the driver
	tick_t       ticks_due[$];         // predicted ticks, oldest first

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_req;
	int hold_ack;
	int hold_left;
	int mismatches;
	int n_reports;
	int n_ticks;
	int n_saturated;
	int n_wraps;
	int cycles;

	task automatic log_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 50)
			$display("ERROR @%0t tick %0d %s: got %0h want %0h", $realtime, n_ticks,
				what, got, want);
		mismatches++;
	endtask

	// expected ticks for one accepted report
	task automatic predict_ticks(input logic [ptop_pkg::FC_W-1:0] ep);
		logic [ptop_pkg::FC_W-1:0]   fc;
		logic [ptop_pkg::IDX_W-1:0]  prev;
		logic [ptop_pkg::IDX_W-1:0]  due;
		logic [ptop_pkg::IDX_W-1:0]  first;
		logic [ptop_pkg::IDX_W-1:0]  idx;
		logic [ptop_pkg::TIME_W-1:0] started;
		logic [ptop_pkg::TIME_W-1:0] sched;
		logic [ptop_pkg::TIME_W-1:0] diff;
		logic [ptop_pkg::IDX_W-1:0]  gap;
		int                          count;
		int                          lim;
		tick_t                       t;
		fc = (ep == '0) ? 32'd1 : ep;
		prev = last_sched_r;
		due = prev + ptop_pkg::IDX_W'(fc);
		first = due;
		count = 1;
		if (mode_r == ptop_pkg::MODE_DELAY) begin
			first = prev + 40'd1;
			started = 64'(period_r) * 64'(ptop_pkg::IDX_W'(delivered_r + 40'd1));
		end else begin
			if (mode_r == ptop_pkg::MODE_CATCHUP) begin
				lim = int'(limit_r);
				if (lim == 0)
					lim = 1;
				if (lim > ptop_pkg::MAX_BURST_DEF)
					lim = ptop_pkg::MAX_BURST_DEF;
				count = (64'(fc) < 64'(lim)) ? int'(fc) : lim;
				first = due - ptop_pkg::IDX_W'(count) + 40'd1;
			end
			started = 64'(period_r) * 64'(due);
		end
		if (due < prev)
			n_wraps++;
		for (int k = 0; k < count; k++) begin
			idx = first + ptop_pkg::IDX_W'(k);
			sched = 64'(period_r) * 64'(idx);
			if (started < sched) begin
				t.late = '0;
			end else begin
				diff = started - sched;
				t.late = (diff > 64'(ptop_pkg::LATE_MAX)) ? ptop_pkg::LATE_MAX
					: diff[ptop_pkg::LATE_W-1:0];
				if (diff > 64'(ptop_pkg::LATE_MAX))
					n_saturated++;
			end
			delivered_r = delivered_r + 40'd1;
			gap = idx - prev - 40'd1;
			t.dn = delivered_r;
			t.idx = idx;
			t.sched = sched;
			t.started = started;
			t.skipped = (k == 0) ? gap[ptop_pkg::FC_W-1:0] : '0;
			t.last = (k + 1 == count);
			ticks_due = {ticks_due, t};
			last_sched_r = idx;
		end
	endtask

	// report driver: holds valid until accepted, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report.valid <= 1'b0;
			report.elapsed_periods <= '0;
		end else begin
			if (report.valid && report.ready) begin
				predict_ticks(report.elapsed_periods);
				n_reports++;
			end
			if (!report.valid || report.ready) begin
				if (reports_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					report.valid <= 1'b1;
					report.elapsed_periods <= reports_pending[0];
					reports_pending.delete(0);
				end else begin
					report.valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off of the tick side, counted here so it is independent of
	// the random stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_ack <= 0;
		end else if (hold_req != hold_ack) begin
			hold_left <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// tick monitor: compare each accepted tick with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick.ready <= 1'b0;
		end else begin
			if (tick.valid && tick.ready) begin
				if (ticks_due.size() == 0) begin
					log_mismatch("unexpected tick, delivery_number", 64'(tick.delivery_number),
						64'd0);
				end else begin
					tick_t w;
					w = ticks_due[0];
					ticks_due.delete(0);
					if (tick.delivery_number !== w.dn)
						log_mismatch("delivery_number", 64'(tick.delivery_number), 64'(w.dn));
					if (tick.sched_index !== w.idx)
						log_mismatch("sched_index", 64'(tick.sched_index), 64'(w.idx));
					if (tick.scheduled_elapsed !== w.sched)
						log_mismatch("scheduled_elapsed", tick.scheduled_elapsed, w.sched);
					if (tick.start_elapsed !== w.started)
						log_mismatch("start_elapsed", tick.start_elapsed, w.started);
					if (tick.lateness !== w.late)
						log_mismatch("lateness", 64'(tick.lateness), 64'(w.late));
					if (tick.skip_count !== w.skipped)
						log_mismatch("skip_count", 64'(tick.skip_count), 64'(w.skipped));
					if (tick.last_of_burst !== w.last)
						log_mismatch("last_of_burst", 64'(tick.last_of_burst), 64'(w.last));
				end
				n_ticks++;
			end
			tick.ready <= (hold_left != 0) ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d ticks outstanding", cycles,
				ticks_due.size());
			$display("periodic_tick_overrun_policy_top verification failed");
			$finish;
		end
	end

	// register write, only issued while the block is quiet
	task automatic write_reg(input logic [ptop_pkg::WR_IDX_W-1:0] idx,
			input logic [ptop_pkg::WR_DATA_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			ptop_pkg::REG_MODE:   mode_r = data[ptop_pkg::MODE_W-1:0];
			ptop_pkg::REG_PERIOD: period_r = data[ptop_pkg::PERIOD_W-1:0];
			ptop_pkg::REG_LIMIT:  limit_r = data[ptop_pkg::LIMIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// wait until no report is queued or in flight and every tick has arrived
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (reports_pending.size() != 0 || report.valid || ticks_due.size() != 0);
	endtask

	task automatic set_idling(input int phase);
		case (phase % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
			default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
		endcase
	endtask

	// random elapsed count, mostly small so catch-up bursts stay varied
	function automatic logic [31:0] rand_fc();
		int r;
		r = $urandom_range(9);
		case (r) inside
			[0:3]:   return 32'($urandom_range(3));
			[4:6]:   return 32'($urandom_range(130));
			7:       return 32'($urandom);
			8:       return FC_MAX;
			default: return 32'($urandom_range(1000));
		endcase
	endfunction

	initial begin : stim
		logic [ptop_pkg::LIMIT_W-1:0] lim_v;
		logic [ptop_pkg::MODE_W-1:0]  mode_v;
		logic [23:0]                  per_v;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		report.valid = 1'b0;
		report.elapsed_periods = '0;
		tick.ready = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 0;
		mismatches = 0;
		n_reports = 0;
		n_ticks = 0;
		n_saturated = 0;
		n_wraps = 0;
		cycles = 0;
		mode_r = ptop_pkg::MODE_RST;
		period_r = ptop_pkg::PERIOD_RST;
		limit_r = ptop_pkg::LIMIT_RST;
		last_sched_r = '0;
		delivered_r = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset registers, coalesce, zero count and full-width counts
		reports_pending = '{32'd0, 32'd1, 32'd5, 32'hAAAA_AAAA, 32'h5555_5555, FC_MAX};
		wait_quiet();

		// delay-next right after big coalesced jumps: started lags, lateness is 0
		write_reg(ptop_pkg::REG_MODE, 24'(ptop_pkg::MODE_DELAY));
		reports_pending = '{32'd3, 32'd0};
		wait_quiet();

		// catch-up at the top limit and the largest period
		write_reg(ptop_pkg::REG_MODE, 24'(ptop_pkg::MODE_CATCHUP));
		write_reg(ptop_pkg::REG_LIMIT, 24'd64);
		write_reg(ptop_pkg::REG_PERIOD, PERIOD_MAX);
		reports_pending = '{32'd100, 32'd10, 32'd1, 32'd0};
		wait_quiet();

		// limit 0 acts as 1, limit above the burst size acts as the burst size
		write_reg(ptop_pkg::REG_LIMIT, 24'd0);
		reports_pending = '{32'd7};
		wait_quiet();
		write_reg(ptop_pkg::REG_LIMIT, 24'd127);
		reports_pending = '{32'd70};
		wait_quiet();

		// unused mode code falls back to coalesce
		write_reg(ptop_pkg::REG_MODE, 24'd3);
		reports_pending = '{32'd9};
		wait_quiet();

		// zero period: every time field stays zero
		write_reg(ptop_pkg::REG_PERIOD, 24'd0);
		write_reg(ptop_pkg::REG_MODE, 24'(ptop_pkg::MODE_CATCHUP));
		write_reg(ptop_pkg::REG_LIMIT, 24'd5);
		reports_pending = '{32'd8};
		wait_quiet();
		write_reg(ptop_pkg::REG_MODE, 24'(ptop_pkg::MODE_DELAY));
		reports_pending = '{32'd2};
		wait_quiet();

		// long tick stall while full bursts keep coming: queue fills and the
		// report side has to back off
		write_reg(ptop_pkg::REG_MODE, 24'(ptop_pkg::MODE_CATCHUP));
		write_reg(ptop_pkg::REG_LIMIT, 24'd64);
		write_reg(ptop_pkg::REG_PERIOD, 24'd1000);
		@(negedge clk);
		hold_req++;
		repeat (10)
			reports_pending = {reports_pending, 32'd200};
		wait_quiet();

		// random sweep: new registers and idling pattern every 25 reports
		for (int s = 0; s < 8; s++) begin
			set_idling(s);
			mode_v = (s < 3) ? ptop_pkg::MODE_W'(s) : ptop_pkg::MODE_W'($urandom_range(3));
			lim_v = (s == 0) ? 7'd64 : ptop_pkg::LIMIT_W'($urandom_range(127));
			case ($urandom_range(3))
				0:       per_v = 24'd1;
				1:       per_v = PERIOD_MAX;
				2:       per_v = 24'($urandom_range(1, 5000));
				default: per_v = 24'($urandom);
			endcase
			write_reg(ptop_pkg::REG_MODE, (24'($urandom) & 24'hFF_FFFC) | 24'(mode_v));
			write_reg(ptop_pkg::REG_LIMIT, (24'($urandom) & 24'hFF_FF80) | 24'(lim_v));
			write_reg(ptop_pkg::REG_PERIOD, per_v);
			repeat (25)
				reports_pending = {reports_pending, rand_fc()};
			wait_quiet();
		end

		// drain window for any stray tick
		repeat (12) @(posedge clk);
		if (ticks_due.size() != 0)
			log_mismatch("ticks never delivered, count", 64'(ticks_due.size()), 64'd0);

		$display("run covered %0d reports and %0d ticks in all overrun modes", n_reports,
			n_ticks);
		$display("including %0d index wraps, %0d saturated latenesses and a %0d-cycle tick stall",
			n_wraps, n_saturated, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("periodic_tick_overrun_policy_top verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("periodic_tick_overrun_policy_top verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ptop_pkg.sv
rtl/ptop_report_if.sv
rtl/ptop_tick_if.sv
rtl/ptop_front.sv
rtl/ptop_queue.sv
rtl/ptop_back.sv
rtl/periodic_tick_overrun_policy_top.sv
test/tb_periodic_tick_overrun_policy_top.sv
